@@ rtl/irt_pkg.sv @@
// ----------------------------------------------------------------------------
// irt_pkg
// Shared types and codes for the interval reservation table.
// ----------------------------------------------------------------------------
package irt_pkg;

    localparam int DAY_W  = 9;
    localparam int USER_W = 32;
    localparam int SLOT_W = 2 * DAY_W + USER_W;

    typedef enum logic [2:0] {
        CMD_TEST   = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_LOCK   = 3'd3,
        CMD_UNLOCK = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    localparam logic [1:0] CFG_FIRST_DAY = 2'd0;
    localparam logic [1:0] CFG_LAST_DAY  = 2'd1;
    localparam logic [1:0] CFG_RES_USED  = 2'd2;

    typedef struct packed {
        logic [DAY_W-1:0]  start_day;
        logic [DAY_W-1:0]  end_day;
        logic [USER_W-1:0] user;
    } slot_t;

endpackage

@@ rtl/irt_ram.sv @@
// ----------------------------------------------------------------------------
// irt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module irt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/interval_reservation_table_core.sv @@
// ----------------------------------------------------------------------------
// interval_reservation_table_core
// Per-resource interval booking table with user locks.
// ----------------------------------------------------------------------------
// Usage: one command transaction enters on s_valid/s_ready and produces
// exactly one status transaction on m_valid/m_ready. Commands are handled
// one at a time. A command first reads the per-resource record (count,
// lock owner, lock day) from a RAM, then walks the resource's interval
// slots in the interval RAM, one slot per cycle. Test and add scan up to
// the stored count; add then shifts the tail up one slot per cycle and
// writes the new interval; remove compacts the list one slot per cycle.
// A bad resource or an unknown command is refused without reading the
// per-resource record. The result sits in an output register;
// s_ready returns the cycle after it has been taken.
// A stalled receiver holds the block with its status pending.
// After reset a clearing pass writes zero to each per-resource record,
// one per cycle, during which s_ready is low.
// Interval slots are not cleared: only slots below the count are read.
// Configuration writes are taken at any time through cfg_we.
// ----------------------------------------------------------------------------
module interval_reservation_table_core
    import irt_pkg::*;
#(
    parameter int NUM_RESOURCES = 64,
    parameter int MAX_INTERVALS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [7:0]  s_resource,
    input  logic [31:0] s_user_id,
    input  logic signed [9:0] s_first_day,
    input  logic signed [9:0] s_last_day,
    input  logic [8:0]  s_today,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status
);

    localparam int RW   = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int SW   = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW   = $clog2(MAX_INTERVALS + 1);
    localparam int DEPTH_R = 1 << RW;
    localparam int DEPTH_S = 1 << (RW + SW);
    localparam int REC_W = CW + USER_W + DAY_W;

    typedef struct packed {
        logic [CW-1:0]     cnt;
        logic [USER_W-1:0] owner;
        logic [DAY_W-1:0]  day;
    } rec_t;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_REC   = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_SHIFT = 8'b0001_0000,
        S_REM   = 8'b0010_0000,
        S_DONE  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [8:0] first_cfg_reg;
    logic [8:0] last_cfg_reg;
    logic [6:0] used_cfg_reg;

    // Latched command
    logic [2:0]        cmd_reg;
    logic [RW-1:0]     res_reg;
    logic [USER_W-1:0] user_reg;
    logic [DAY_W-1:0]  sday_reg, eday_reg, today_reg;
    logic              bad_iv_reg;
    rec_t              rec_reg, rec_next;
    logic [CW-1:0]     idx_reg, idx_next;   // read pointer
    logic [CW-1:0]     k_reg, k_next;       // write pointer for remove
    logic              rd_pend_reg, rd_pend_next;
    logic [1:0]        st_reg, st_next;
    logic [RW-1:0]     clr_reg;

    // RAM ports
    logic          rec_we;
    logic [RW-1:0] rec_waddr, rec_raddr;
    rec_t          rec_wdata, rec_rdata;
    logic          slot_we;
    logic [SW-1:0] slot_widx, slot_ridx;
    slot_t         slot_wdata, slot_rdata;

    irt_ram #(.WIDTH(REC_W), .DEPTH(DEPTH_R)) u_rec_ram (
        .aclk(aclk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
        .raddr(rec_raddr), .rdata(rec_rdata)
    );

    irt_ram #(.WIDTH(SLOT_W), .DEPTH(DEPTH_S)) u_slot_ram (
        .aclk(aclk), .we(slot_we), .waddr({res_reg, slot_widx}),
        .wdata(slot_wdata), .raddr({res_reg, slot_ridx}), .rdata(slot_rdata)
    );

    // Input checks
    logic s_res_ok, s_iv_bad;
    always_comb begin
        s_res_ok = ({1'b0, s_resource} < {1'b0, used_cfg_reg})
                 && ({1'b0, s_resource} < 9'(NUM_RESOURCES));
        s_iv_bad = (s_first_day > s_last_day)
                 || (s_first_day < $signed({1'b0, first_cfg_reg}))
                 || (s_last_day > $signed({1'b0, last_cfg_reg}));
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = (state_reg == S_OUT);
    assign m_status = st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_cfg_reg <= 9'd0;
            last_cfg_reg  <= 9'd365;
            used_cfg_reg  <= 7'd64;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FIRST_DAY: first_cfg_reg <= cfg_wdata;
                CFG_LAST_DAY:  last_cfg_reg  <= cfg_wdata;
                CFG_RES_USED:  used_cfg_reg  <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    logic [CW-1:0] cnt_c;
    logic          hit_over, hit_after;
    always_comb begin
        cnt_c = rec_reg.cnt;
        hit_over  = ({1'b0, slot_rdata.end_day} >= {1'b0, sday_reg});
        hit_after = (slot_rdata.start_day > eday_reg);
    end

    always_comb begin
        state_next   = state_reg;
        rec_next     = rec_reg;
        idx_next     = idx_reg;
        k_next       = k_reg;
        rd_pend_next = 1'b0;
        st_next      = st_reg;
        rec_we       = 1'b0;
        rec_waddr    = res_reg;
        rec_wdata    = rec_reg;
        rec_raddr    = s_resource[RW-1:0];
        slot_we      = 1'b0;
        slot_widx    = idx_reg[SW-1:0];
        slot_wdata   = slot_rdata;
        slot_ridx    = idx_reg[SW-1:0];
        case (state_reg)
            S_CLEAR: begin
                rec_we    = 1'b1;
                rec_waddr = clr_reg;
                rec_wdata = '0;
                if (clr_reg == RW'(DEPTH_R - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    if (!s_res_ok || s_cmd > CMD_UNLOCK) begin
                        st_next    = ST_REFUSED;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_REC;
                    end
                end
            end
            S_REC: begin
                rec_next  = rec_rdata;
                idx_next  = '0;
                k_next    = '0;
                st_next   = ST_OK;
                // fetch the first slot of the list
                slot_ridx = '0;
                case (cmd_reg)
                    CMD_TEST, CMD_ADD: begin
                        if (bad_iv_reg) begin
                            st_next    = ST_REFUSED;
                            state_next = S_OUT;
                        end else begin
                            rd_pend_next = (rec_rdata.cnt != '0);
                            state_next   = S_SCAN;
                        end
                    end
                    CMD_REMOVE: begin
                        rd_pend_next = (rec_rdata.cnt != '0);
                        state_next   = S_REM;
                    end
                    CMD_LOCK: begin
                        if (rec_rdata.owner == '0 || rec_rdata.owner == user_reg
                            || rec_rdata.day < today_reg) begin
                            rec_next.owner = user_reg;
                            rec_next.day   = today_reg;
                        end else begin
                            st_next = ST_REFUSED;
                        end
                        state_next = S_DONE;
                    end
                    default: begin
                        rec_next.owner = '0;
                        state_next     = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                // slot idx_reg data is valid when rd_pend_reg
                if (rd_pend_reg) begin
                    if (hit_over && !hit_after) begin
                        st_next    = ST_REFUSED;
                        state_next = S_OUT;
                    end else if (hit_over) begin
                        state_next = S_DONE;
                    end else begin
                        idx_next     = idx_reg + 1'b1;
                        slot_ridx    = SW'(idx_reg + 1'b1);
                        rd_pend_next = (idx_reg + 1'b1 != cnt_c);
                        if (idx_reg + 1'b1 == cnt_c) state_next = S_DONE;
                    end
                end else begin
                    state_next = S_DONE;
                end
                if (state_next == S_DONE) begin
                    if (cmd_reg == CMD_TEST) begin
                        state_next = S_OUT;
                    end else if (cnt_c >= CW'(MAX_INTERVALS)) begin
                        st_next    = ST_FULL;
                        state_next = S_OUT;
                    end else begin
                        // idx_next is the insert position; shift from top
                        k_next       = cnt_c;
                        slot_ridx    = SW'(cnt_c - 1'b1);
                        rd_pend_next = (cnt_c != idx_next);
                        state_next   = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                // k_reg is the destination slot, idx_reg the insert point
                if (rd_pend_reg) begin
                    slot_we      = 1'b1;
                    slot_widx    = k_reg[SW-1:0];
                    slot_wdata   = slot_rdata;
                    k_next       = k_reg - 1'b1;
                    slot_ridx    = SW'(k_reg - 2'd2);
                    rd_pend_next = (k_reg - 1'b1 != idx_reg);
                end else begin
                    slot_we    = 1'b1;
                    slot_widx  = idx_reg[SW-1:0];
                    slot_wdata = '{start_day: sday_reg, end_day: eday_reg,
                                   user: user_reg};
                    rec_next.cnt   = cnt_c + 1'b1;
                    rec_next.owner = '0;
                    state_next     = S_DONE;
                end
            end
            S_REM: begin
                if (rd_pend_reg) begin
                    if (slot_rdata.user != user_reg) begin
                        slot_we   = 1'b1;
                        slot_widx = k_reg[SW-1:0];
                        k_next    = k_reg + 1'b1;
                    end
                    idx_next     = idx_reg + 1'b1;
                    slot_ridx    = SW'(idx_reg + 1'b1);
                    rd_pend_next = (idx_reg + 1'b1 != cnt_c);
                end else begin
                    rec_next.cnt = k_reg;
                    state_next   = S_DONE;
                end
            end
            S_DONE: begin
                rec_we     = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            rd_pend_reg <= 1'b0;
            st_reg      <= ST_OK;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_reg + 1'b1;
            rd_pend_reg <= rd_pend_next;
            st_reg      <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            cmd_reg    <= s_cmd;
            res_reg    <= s_resource[RW-1:0];
            user_reg   <= s_user_id;
            sday_reg   <= s_first_day[DAY_W-1:0];
            eday_reg   <= s_last_day[DAY_W-1:0];
            today_reg  <= s_today;
            bad_iv_reg <= s_iv_bad;
        end
        rec_reg <= rec_next;
        idx_reg <= idx_next;
        k_reg   <= k_next;
    end

endmodule

@@ rtl/irt_checker.sv @@
// ----------------------------------------------------------------------------
// irt_checker
// Port-level checks for the interval reservation table.
// ----------------------------------------------------------------------------
module irt_checker
    import irt_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_status
);

    // one command at a time: no input while a result is pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready while result pending");

    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("second transaction taken");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_REFUSED
                     || m_status == ST_FULL)) else $error("bad status");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)))
        else $error("result dropped");

endmodule

bind interval_reservation_table_core irt_checker u_irt_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status)
);
